@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the centered RMSprop update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmscm: implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmscm: next-cycle check failed");

`endif

@@ rtl/rmscm_pkg.sv @@
// Shared constants and types of the centered RMSprop update block.
package rmscm_pkg;

  localparam int ELEMENT_COUNT = 1024;
  localparam int IDX_W         = 10;
  localparam int VALUE_W       = 32;
  localparam int CFG_DATA_W    = 25;

  // Root of a 56-bit radicand has 28 bits; the dividend is step times |g|.
  localparam int ROOT_W = 28;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int DVD_W  = 56;
  localparam int DVS_W  = ROOT_W;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [24:0] ONE_Q24 = 25'd16777216;

  localparam logic [16:0] DECAY_RESET    = 17'd62259;
  localparam logic [16:0] MOMENTUM_RESET = 17'd58982;
  localparam logic [24:0] STEP_RESET     = 25'd167772;
  localparam logic [24:0] EPS_RESET      = 25'd17;

  typedef enum logic [1:0] {
    REG_DECAY    = 2'd0,
    REG_MOMENTUM = 2'd1,
    REG_STEP     = 2'd2,
    REG_EPS      = 2'd3
  } cfg_reg_t;

  // Sideband that travels with an item through the long arithmetic pipes.
  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] weight;
    logic                      neg;
    logic                      flag;
  } tag_t;

endpackage

@@ rtl/rmsprop_centered_momentum_update_top.sv @@
// Top level of the centered RMSprop with momentum weight update block.
//
//   channel   direction  handshake                payload
//   in        sink       in_valid / in_stall      element_index, weight_in, gradient
//   out       source     out_valid / out_stall    weight_out, saturated
//   cfg       sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction is taken per clock while in_stall is low; its result passes through
// the 28-stage square root and the 56-stage quotient pipeline.
// After reset both state memories are swept to zero, all 1024 entries, one entry per cycle;
// in_stall stays high during the sweep, while cfg writes are taken at any time.
// The whole pipeline moves on one enable: it advances whenever the output register
// is empty or its transaction is being taken, so out_stall on a full output register freezes every stage.
`include "assert_macros.svh"

module rmsprop_centered_momentum_update_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rmscm_pkg::IDX_W-1:0]         element_index,
  input  logic signed [rmscm_pkg::VALUE_W-1:0] weight_in,
  input  logic signed [rmscm_pkg::VALUE_W-1:0] gradient,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmscm_pkg::VALUE_W-1:0] weight_out,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [rmscm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } phase_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } sat_t;

  // Saturate a wide signed value to the 32-bit stored range.
  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t res;
    if (x[63:31] == {33{x[63]}}) begin
      res.value = x[31:0];
      res.clip  = 1'b0;
    end else begin
      res.value = x[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      res.clip  = 1'b1;
    end
    return res;
  endfunction

  // Configuration registers. The port always takes a write.
  logic [16:0] decay;
  logic [16:0] momentum;
  logic [24:0] step;
  logic [24:0] eps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay    <= rmscm_pkg::DECAY_RESET;
      momentum <= rmscm_pkg::MOMENTUM_RESET;
      step     <= rmscm_pkg::STEP_RESET;
      eps      <= rmscm_pkg::EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rmscm_pkg::cfg_reg_t'(cfg_index))
        rmscm_pkg::REG_DECAY:    decay    <= cfg_data[16:0];
        rmscm_pkg::REG_MOMENTUM: momentum <= cfg_data[16:0];
        rmscm_pkg::REG_STEP:     step     <= cfg_data;
        rmscm_pkg::REG_EPS:      eps      <= cfg_data;
      endcase
    end
  end

  // Factors above one are used as one.
  logic [16:0]        d_lim;
  logic [16:0]        cd;
  logic [16:0]        mu_lim;
  logic [24:0]        step_lim;
  logic signed [17:0] d_s;
  logic signed [17:0] cd_s;
  logic signed [17:0] mu_s;

  assign d_lim    = (decay > rmscm_pkg::ONE_Q16) ? rmscm_pkg::ONE_Q16 : decay;
  assign cd       = rmscm_pkg::ONE_Q16 - d_lim;
  assign mu_lim   = (momentum > rmscm_pkg::ONE_Q16) ? rmscm_pkg::ONE_Q16 : momentum;
  assign step_lim = (step > rmscm_pkg::ONE_Q24) ? rmscm_pkg::ONE_Q24 : step;
  assign d_s      = {1'b0, d_lim};
  assign cd_s     = {1'b0, cd};
  assign mu_s     = {1'b0, mu_lim};

  // Memory clearing sweep after reset.
  phase_t                      state;
  logic [rmscm_pkg::IDX_W-1:0] clr_addr;
  logic                        clearing;

  assign clearing = (state == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == rmscm_pkg::IDX_W'(rmscm_pkg::ELEMENT_COUNT - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          clr_addr <= clr_addr;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // Global pipeline enable, set by the output register.
  logic adv;
  logic acc;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv || clearing;
  assign acc      = in_valid && !in_stall;

  // Stage 1: accepted transaction, gradient products.
  rmscm_pkg::tag_t     s1_tag;
  logic signed [31:0]  s1_g;
  logic [31:0]         gmag;
  logic [63:0]         sq_full;
  logic signed [49:0]  gcd_full;
  logic [56:0]         dvd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else if (adv) begin
      s1_tag.valid  <= acc;
      s1_tag.idx    <= element_index;
      s1_tag.weight <= weight_in;
      s1_tag.neg    <= gradient[31];
      s1_tag.flag   <= 1'b0;
      s1_g          <= gradient;
    end
  end

  assign gmag     = s1_g[31] ? (32'd0 - s1_g) : s1_g;
  assign sq_full  = gmag * gmag;
  assign gcd_full = s1_g * cd_s;
  assign dvd_full = step_lim * gmag;

  // Stage 2: read-modify-write of the mean square and mean gradient.
  rmscm_pkg::tag_t     s2_tag;
  logic [38:0]         s2_sq;
  logic signed [33:0]  s2_gcd;
  logic [55:0]         s2_dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.valid <= 1'b0;
    end else if (adv) begin
      s2_tag <= s1_tag;
      s2_sq  <= sq_full[62:24];
      s2_gcd <= gcd_full[49:16];
      s2_dvd <= dvd_full[55:0];
    end
  end

  logic [63:0]        nm_rdata;
  logic [63:0]        nm_fwd;
  logic               nm_fwd_hit;
  logic [63:0]        nm_cur;
  logic signed [31:0] n_old;
  logic signed [31:0] m_old;
  logic signed [49:0] nd_full;
  logic signed [49:0] md_full;
  logic [55:0]        sqcd_full;
  logic signed [33:0] nd;
  logic signed [33:0] md;
  logic signed [41:0] n_sum;
  logic signed [34:0] m_sum;
  sat_t               n_sat;
  sat_t               m_sat;
  logic               nm_we;
  logic [rmscm_pkg::IDX_W-1:0] nm_waddr;
  logic [63:0]        nm_wdata;

  // The entry written by stage 2 in the cycle the next transaction reads it arrives
  // through the forward register, since the memory returns the old contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      nm_fwd_hit <= 1'b0;
    end else if (adv) begin
      nm_fwd_hit <= s2_tag.valid && s1_tag.valid && (s2_tag.idx == s1_tag.idx);
      nm_fwd     <= {n_sat.value, m_sat.value};
    end
  end

  assign nm_cur    = nm_fwd_hit ? nm_fwd : nm_rdata;
  assign n_old     = nm_cur[63:32];
  assign m_old     = nm_cur[31:0];
  assign nd_full   = n_old * d_s;
  assign md_full   = m_old * d_s;
  assign sqcd_full = s2_sq * cd;
  assign nd        = nd_full[49:16];
  assign md        = md_full[49:16];
  assign n_sum     = {{8{nd[33]}}, nd} + {2'b00, sqcd_full[55:16]};
  assign m_sum     = {md[33], md} + {s2_gcd[33], s2_gcd};
  assign n_sat     = sat32(64'(n_sum));
  assign m_sat     = sat32(64'(m_sum));

  assign nm_we    = clearing || (adv && s2_tag.valid);
  assign nm_waddr = clearing ? clr_addr : s2_tag.idx;
  assign nm_wdata = clearing ? 64'd0 : {n_sat.value, m_sat.value};

  rmscm_ram #(
    .WIDTH (64),
    .DEPTH (rmscm_pkg::ELEMENT_COUNT),
    .AW    (rmscm_pkg::IDX_W)
  ) u_nm_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .re    (adv),
    .raddr (s1_tag.idx),
    .rdata (nm_rdata)
  );

  // Stage 3: square of the mean gradient.
  rmscm_pkg::tag_t    s3_tag;
  rmscm_pkg::tag_t    s3_tag_next;
  logic signed [31:0] s3_n;
  logic signed [31:0] s3_m;
  logic [55:0]        s3_dvd;
  logic [31:0]        mmag;
  logic [63:0]        msq_full;

  always_comb begin
    s3_tag_next      = s2_tag;
    s3_tag_next.flag = s2_tag.flag | n_sat.clip | m_sat.clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag.valid <= 1'b0;
    end else if (adv) begin
      s3_tag <= s3_tag_next;
      s3_n   <= n_sat.value;
      s3_m   <= m_sat.value;
      s3_dvd <= s2_dvd;
    end
  end

  assign mmag     = s3_m[31] ? (32'd0 - s3_m) : s3_m;
  assign msq_full = mmag * mmag;

  // Stage 4: variance, clamped at zero, plus epsilon.
  rmscm_pkg::tag_t    s4_tag;
  logic signed [31:0] s4_n;
  logic [39:0]        s4_msq;
  logic [55:0]        s4_dvd;
  logic               n_pos;
  logic [30:0]        var_val;
  logic [31:0]        rad_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag.valid <= 1'b0;
    end else if (adv) begin
      s4_tag <= s3_tag;
      s4_n   <= s3_n;
      s4_msq <= msq_full[63:24];
      s4_dvd <= s3_dvd;
    end
  end

  assign n_pos   = !s4_n[31] && (s4_n != 32'sd0);
  assign var_val = (n_pos && (s4_msq < {9'd0, s4_n[30:0]})) ?
                   (s4_n[30:0] - s4_msq[30:0]) : 31'd0;
  assign rad_val = {1'b0, var_val} + {7'd0, eps};

  // Stage 5: radicand register feeding the square root.
  rmscm_pkg::tag_t                s5_tag;
  logic [rmscm_pkg::RAD_W-1:0]    s5_rad;
  logic [55:0]                    s5_dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_tag.valid <= 1'b0;
    end else if (adv) begin
      s5_tag <= s4_tag;
      s5_rad <= {rad_val, 24'd0};
      s5_dvd <= s4_dvd;
    end
  end

  rmscm_pkg::tag_t                sq_tag;
  logic [rmscm_pkg::ROOT_W-1:0]   sq_root;
  logic [rmscm_pkg::DVD_W-1:0]    sq_dvd;
  logic [rmscm_pkg::DVS_W-1:0]    divisor;

  rmscm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_tag   (s5_tag),
    .in_rad   (s5_rad),
    .in_dvd   (s5_dvd),
    .out_tag  (sq_tag),
    .out_root (sq_root),
    .out_dvd  (sq_dvd)
  );

  // A zero root only happens with a zero epsilon; it divides by one LSB.
  assign divisor = (sq_root == '0) ? rmscm_pkg::DVS_W'(1) : sq_root;

  rmscm_pkg::tag_t              dv_tag;
  logic [rmscm_pkg::DVD_W-1:0]  dv_quo;

  rmscm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_tag  (sq_tag),
    .in_dvd  (sq_dvd),
    .in_dvs  (divisor),
    .out_tag (dv_tag),
    .out_quo (dv_quo)
  );

  // Velocity stage: read-modify-write of the momentum memory.
  rmscm_pkg::tag_t              sv_tag;
  logic [rmscm_pkg::DVD_W-1:0]  sv_quo;
  logic [31:0]                  v_rdata;
  logic [31:0]                  v_fwd;
  logic                         v_fwd_hit;
  logic signed [31:0]           v_old;
  logic signed [49:0]           vmu_full;
  logic signed [33:0]           vmu;
  logic signed [56:0]           term;
  logic signed [57:0]           v_sum;
  sat_t                         v_sat;
  logic                         v_we;
  logic [rmscm_pkg::IDX_W-1:0]  v_waddr;
  logic [31:0]                  v_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv_tag.valid <= 1'b0;
      v_fwd_hit    <= 1'b0;
    end else if (adv) begin
      sv_tag    <= dv_tag;
      sv_quo    <= dv_quo;
      v_fwd_hit <= sv_tag.valid && dv_tag.valid && (sv_tag.idx == dv_tag.idx);
      v_fwd     <= v_sat.value;
    end
  end

  assign v_old    = v_fwd_hit ? v_fwd : v_rdata;
  assign vmu_full = v_old * mu_s;
  assign vmu      = vmu_full[49:16];
  // The step term opposes the gradient.
  assign term     = sv_tag.neg ? {1'b0, sv_quo} : -{1'b0, sv_quo};
  assign v_sum    = {{24{vmu[33]}}, vmu} + {term[56], term};
  assign v_sat    = sat32(64'(v_sum));

  assign v_we    = clearing || (adv && sv_tag.valid);
  assign v_waddr = clearing ? clr_addr : sv_tag.idx;
  assign v_wdata = clearing ? 32'd0 : v_sat.value;

  rmscm_ram #(
    .WIDTH (32),
    .DEPTH (rmscm_pkg::ELEMENT_COUNT),
    .AW    (rmscm_pkg::IDX_W)
  ) u_v_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (adv),
    .raddr (dv_tag.idx),
    .rdata (v_rdata)
  );

  // Weight stage: w + v, saturated.
  rmscm_pkg::tag_t    sx_tag;
  rmscm_pkg::tag_t    sx_tag_next;
  logic signed [31:0] sx_v;
  logic signed [32:0] w_sum;
  sat_t               w_sat;

  always_comb begin
    sx_tag_next      = sv_tag;
    sx_tag_next.flag = sv_tag.flag | v_sat.clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sx_tag.valid <= 1'b0;
    end else if (adv) begin
      sx_tag <= sx_tag_next;
      sx_v   <= v_sat.value;
    end
  end

  assign w_sum = {sx_tag.weight[31], sx_tag.weight} + {sx_v[31], sx_v};
  assign w_sat = sat32(64'(w_sum));

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid  <= sx_tag.valid;
      weight_out <= w_sat.value;
      saturated  <= sx_tag.flag | w_sat.clip;
    end
  end

  // A forwarded value is only ever held for a live transaction in its stage.
  `ASSERT_IMPLY(a_nm_fwd_live, clk, rst, nm_fwd_hit, s2_tag.valid)
  `ASSERT_IMPLY(a_v_fwd_live, clk, rst, v_fwd_hit, sv_tag.valid)
  // Nothing is in flight while the memories are being cleared.
  `ASSERT_IMPLY(a_clear_empty, clk, rst, clearing, !s1_tag.valid && !out_valid)
  // The sweep runs to the last entry before handing over.
  `ASSERT_NEXT(a_clear_runs, clk, rst,
               clearing && (clr_addr != rmscm_pkg::IDX_W'(rmscm_pkg::ELEMENT_COUNT - 1)),
               clearing)

endmodule

@@ rtl/rmscm_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module rmscm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rmscm_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module rmscm_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  rmscm_pkg::tag_t                in_tag,
  input  logic [rmscm_pkg::RAD_W-1:0]    in_rad,
  input  logic [rmscm_pkg::DVD_W-1:0]    in_dvd,
  output rmscm_pkg::tag_t                out_tag,
  output logic [rmscm_pkg::ROOT_W-1:0]   out_root,
  output logic [rmscm_pkg::DVD_W-1:0]    out_dvd
);

  rmscm_pkg::tag_t                 tag_q  [0:rmscm_pkg::ROOT_W];
  logic [rmscm_pkg::RAD_W-1:0]     rad_q  [0:rmscm_pkg::ROOT_W];
  logic [rmscm_pkg::ROOT_W:0]      rem_q  [0:rmscm_pkg::ROOT_W];
  logic [rmscm_pkg::ROOT_W-1:0]    root_q [0:rmscm_pkg::ROOT_W];
  logic [rmscm_pkg::DVD_W-1:0]     dvd_q  [0:rmscm_pkg::ROOT_W];

  assign tag_q[0]  = in_tag;
  assign rad_q[0]  = in_rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign dvd_q[0]  = in_dvd;

  for (genvar k = 0; k < rmscm_pkg::ROOT_W; k++) begin : g_stage
    logic [rmscm_pkg::ROOT_W+2:0] rem_try;
    logic [rmscm_pkg::ROOT_W+2:0] trial;
    logic [rmscm_pkg::ROOT_W+2:0] diff;
    logic                         ge;

    // Bring down the next radicand pair and try the next root bit.
    assign rem_try = {rem_q[k], rad_q[k][rmscm_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_q[k], 2'b01};
    assign ge      = (rem_try >= trial);
    assign diff    = rem_try - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[k+1].valid <= 1'b0;
      end else if (en) begin
        tag_q[k+1]  <= tag_q[k];
        rad_q[k+1]  <= {rad_q[k][rmscm_pkg::RAD_W-3:0], 2'b00};
        rem_q[k+1]  <= ge ? diff[rmscm_pkg::ROOT_W:0] : rem_try[rmscm_pkg::ROOT_W:0];
        root_q[k+1] <= {root_q[k][rmscm_pkg::ROOT_W-2:0], ge};
        dvd_q[k+1]  <= dvd_q[k];
      end
    end
  end

  assign out_tag  = tag_q[rmscm_pkg::ROOT_W];
  assign out_root = root_q[rmscm_pkg::ROOT_W];
  assign out_dvd  = dvd_q[rmscm_pkg::ROOT_W];

endmodule

@@ rtl/rmscm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module rmscm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  rmscm_pkg::tag_t               in_tag,
  input  logic [rmscm_pkg::DVD_W-1:0]   in_dvd,
  input  logic [rmscm_pkg::DVS_W-1:0]   in_dvs,
  output rmscm_pkg::tag_t               out_tag,
  output logic [rmscm_pkg::DVD_W-1:0]   out_quo
);

  rmscm_pkg::tag_t                tag_q  [0:rmscm_pkg::DVD_W];
  logic [rmscm_pkg::DVD_W-1:0]    word_q [0:rmscm_pkg::DVD_W];
  logic [rmscm_pkg::DVS_W-1:0]    rem_q  [0:rmscm_pkg::DVD_W];
  logic [rmscm_pkg::DVS_W-1:0]    dvs_q  [0:rmscm_pkg::DVD_W];

  assign tag_q[0]  = in_tag;
  assign word_q[0] = in_dvd;
  assign rem_q[0]  = '0;
  assign dvs_q[0]  = in_dvs;

  for (genvar k = 0; k < rmscm_pkg::DVD_W; k++) begin : g_stage
    logic [rmscm_pkg::DVS_W:0] rem_try;
    logic [rmscm_pkg::DVS_W:0] diff;
    logic                      ge;

    // The word shifts dividend bits out at the top and quotient bits in at the bottom.
    assign rem_try = {rem_q[k], word_q[k][rmscm_pkg::DVD_W-1]};
    assign ge      = (rem_try >= {1'b0, dvs_q[k]});
    assign diff    = rem_try - {1'b0, dvs_q[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[k+1].valid <= 1'b0;
      end else if (en) begin
        tag_q[k+1]  <= tag_q[k];
        word_q[k+1] <= {word_q[k][rmscm_pkg::DVD_W-2:0], ge};
        rem_q[k+1]  <= ge ? diff[rmscm_pkg::DVS_W-1:0] : rem_try[rmscm_pkg::DVS_W-1:0];
        dvs_q[k+1]  <= dvs_q[k];
      end
    end
  end

  assign out_tag = tag_q[rmscm_pkg::DVD_W];
  assign out_quo = word_q[rmscm_pkg::DVD_W];

endmodule
